FILE: hdl/tkss_pkg.sv
// ----------------------------------------------------------------------------
// Top-k score selector package
// Shared widths, codes and types for the score table and query engine.
// ----------------------------------------------------------------------------
package tkss_pkg;

    localparam int ENTRIES    = 64;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int MAX_OUT    = 64;

    localparam int ACTION_W   = 2;
    localparam int ENTRY_W    = 6;
    localparam int AMOUNT_W   = 24;
    localparam int WANT_W     = 7;
    localparam int SCORE_W    = 31;
    localparam int RANK_W     = 6;
    localparam int CFG_W      = 7;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [APB_AW-3:0] REG_IN_USE   = '0;
    localparam logic [CFG_W-1:0]  IN_USE_RESET = CFG_W'(64);
    localparam logic [SCORE_W-1:0] SCORE_MAX   = {SCORE_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QHIGH = 2'd2,
        ACT_QLOW  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_index;
        logic [SCORE_W-1:0] score;
        logic [RANK_W-1:0]  rank;
        logic               last;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result res;
    } t_out_req;

endpackage

FILE: hdl/tkss_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tkss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tkss_cfg.sv
// ----------------------------------------------------------------------------
// Top-k score selector register block
// Holds the in-use entry count and derives the clamped active count.
// ----------------------------------------------------------------------------
module tkss_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tkss_pkg::APB_AW-1:0]  paddr,
    input  logic [tkss_pkg::APB_DW-1:0]  pwdata,
    output logic [tkss_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [tkss_pkg::CNT_W-1:0]   o_active
);

    logic [tkss_pkg::CFG_W-1:0] r_in_use;
    logic                       hit;

    assign hit    = (paddr[tkss_pkg::APB_AW-1:2] == tkss_pkg::REG_IN_USE);
    assign pready = 1'b1;
    assign prdata = hit ? tkss_pkg::APB_DW'(r_in_use) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= tkss_pkg::IN_USE_RESET;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_in_use <= pwdata[tkss_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        if (r_in_use == '0) begin
            o_active = tkss_pkg::CNT_W'(1);
        end else if (32'(r_in_use) > tkss_pkg::ENTRIES) begin
            o_active = tkss_pkg::CNT_W'(tkss_pkg::ENTRIES);
        end else begin
            o_active = tkss_pkg::CNT_W'(r_in_use);
        end
    end

endmodule

FILE: hdl/tkss_engine.sv
// ----------------------------------------------------------------------------
// Top-k score selector engine
// Sequencer around the score RAM: clear, saturating add and repeated
// selection scans that pick the best untaken entry per pass.
// ----------------------------------------------------------------------------
module tkss_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tkss_pkg::t_action             i_action,
    input  logic [tkss_pkg::ENTRY_W-1:0]  i_entry,
    input  logic [tkss_pkg::AMOUNT_W-1:0] i_amount,
    input  logic [tkss_pkg::WANT_W-1:0]   i_want,
    input  logic [tkss_pkg::CNT_W-1:0]    i_active,
    input  logic                          i_out_free,
    output tkss_pkg::t_out_req            o_out
);

    tkss_pkg::t_state r_state, n_state;

    logic [tkss_pkg::ENTRIES-1:0]  r_valid;
    logic                          r_prev_valid;
    logic [tkss_pkg::IDX_W-1:0]    r_prev_idx;
    logic [tkss_pkg::SCORE_W-1:0]  r_prev_score;
    logic                          r_rd_valid;
    logic                          r_found;
    logic [tkss_pkg::IDX_W-1:0]    r_best_idx;
    logic [tkss_pkg::SCORE_W-1:0]  r_best_score;
    logic [tkss_pkg::IDX_W-1:0]    r_scan_addr;
    logic                          r_issue_done;
    logic                          r_cmp_valid;
    logic [tkss_pkg::IDX_W-1:0]    r_cmp_idx;
    logic [tkss_pkg::WANT_W-1:0]   r_rank;
    logic [tkss_pkg::WANT_W-1:0]   r_k;
    logic                          r_low;
    logic [tkss_pkg::IDX_W-1:0]    r_add_idx;
    logic [tkss_pkg::AMOUNT_W-1:0] r_add_amt;

    logic                          accept;
    logic                          in_range;
    logic [tkss_pkg::WANT_W-1:0]   k_calc;
    logic [tkss_pkg::IDX_W-1:0]    last_idx;
    logic [tkss_pkg::SCORE_W-1:0]  rd_score;
    logic [tkss_pkg::SCORE_W:0]    sum;
    logic                          better;
    logic                          eligible;
    logic                          take;
    logic                          is_last;

    logic                          rd_en;
    logic [tkss_pkg::IDX_W-1:0]    rd_addr;
    logic [tkss_pkg::SCORE_W-1:0]  rd_data;
    logic                          wr_en;
    logic [tkss_pkg::SCORE_W-1:0]  wr_data;

    tkss_ram #(
        .WIDTH (tkss_pkg::SCORE_W),
        .DEPTH (tkss_pkg::ENTRIES)
    ) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_add_idx),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // An entry is still untaken when it ranks strictly after the previous
    // pick in (score, index) order, so no per-entry taken flags are needed.
    assign o_in_ready = (r_state == tkss_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_entry) < 32'(i_active));
    assign last_idx   = tkss_pkg::IDX_W'(i_active - tkss_pkg::CNT_W'(1));
    assign rd_score   = r_rd_valid ? rd_data : '0;
    assign sum        = {1'b0, rd_score} + (tkss_pkg::SCORE_W + 1)'(r_add_amt);
    assign wr_data    = sum[tkss_pkg::SCORE_W] ? tkss_pkg::SCORE_MAX
                                               : sum[tkss_pkg::SCORE_W-1:0];
    assign better     = r_low ? (rd_score < r_best_score) : (rd_score > r_best_score);
    assign eligible   = !r_prev_valid
                        || (r_low ? (rd_score > r_prev_score) : (rd_score < r_prev_score))
                        || ((rd_score == r_prev_score) && (r_cmp_idx > r_prev_idx));
    assign take       = r_cmp_valid && eligible && (!r_found || better);
    assign is_last    = (r_rank == r_k - tkss_pkg::WANT_W'(1));

    always_comb begin
        k_calc = i_want;
        if (32'(k_calc) > 32'(i_active)) begin
            k_calc = tkss_pkg::WANT_W'(i_active);
        end
        if (32'(k_calc) > tkss_pkg::MAX_OUT) begin
            k_calc = tkss_pkg::WANT_W'(tkss_pkg::MAX_OUT);
        end
    end

    always_comb begin
        n_state     = r_state;
        rd_en       = 1'b0;
        rd_addr     = r_scan_addr;
        wr_en       = 1'b0;
        o_out.push  = 1'b0;
        o_out.res.entry_index = tkss_pkg::ENTRY_W'(r_best_idx);
        o_out.res.score       = r_best_score;
        o_out.res.rank        = tkss_pkg::RANK_W'(r_rank);
        o_out.res.last        = is_last;
        case (r_state)
            tkss_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        tkss_pkg::ACT_ADD: begin
                            if (in_range) begin
                                rd_en   = 1'b1;
                                rd_addr = tkss_pkg::IDX_W'(i_entry);
                                n_state = tkss_pkg::ST_ADD;
                            end
                        end
                        tkss_pkg::ACT_QHIGH, tkss_pkg::ACT_QLOW: begin
                            if (k_calc != '0) begin
                                n_state = tkss_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tkss_pkg::ST_ADD: begin
                wr_en   = 1'b1;
                n_state = tkss_pkg::ST_IDLE;
            end
            tkss_pkg::ST_SCAN: begin
                rd_en = !r_issue_done;
                if (r_cmp_valid && (r_cmp_idx == last_idx)) begin
                    n_state = tkss_pkg::ST_EMIT;
                end
            end
            tkss_pkg::ST_EMIT: begin
                if (i_out_free) begin
                    o_out.push = 1'b1;
                    n_state    = is_last ? tkss_pkg::ST_IDLE : tkss_pkg::ST_SCAN;
                end
            end
            default: begin
                n_state = tkss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tkss_pkg::ST_IDLE;
            r_valid      <= '0;
            r_cmp_valid  <= 1'b0;
            r_issue_done <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= (r_state == tkss_pkg::ST_SCAN) && !r_issue_done;
            if (accept && (i_action == tkss_pkg::ACT_CLEAR)) begin
                r_valid <= '0;
            end
            if (wr_en) begin
                r_valid[r_add_idx] <= 1'b1;
            end
            if ((r_state == tkss_pkg::ST_SCAN) && !r_issue_done
                    && (r_scan_addr == last_idx)) begin
                r_issue_done <= 1'b1;
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (o_out.push || accept) begin
                r_issue_done <= 1'b0;
                r_found      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[rd_addr];
        r_cmp_idx  <= r_scan_addr;
        if ((r_state == tkss_pkg::ST_SCAN) && !r_issue_done && (r_scan_addr != last_idx)) begin
            r_scan_addr <= r_scan_addr + tkss_pkg::IDX_W'(1);
        end
        if (take) begin
            r_best_idx   <= r_cmp_idx;
            r_best_score <= rd_score;
        end
        if (o_out.push) begin
            r_prev_valid <= 1'b1;
            r_prev_idx   <= r_best_idx;
            r_prev_score <= r_best_score;
            r_rank       <= r_rank + tkss_pkg::WANT_W'(1);
            r_scan_addr  <= '0;
        end
        if (accept) begin
            r_prev_valid <= 1'b0;
            r_rank       <= '0;
            r_k          <= k_calc;
            r_low        <= (i_action == tkss_pkg::ACT_QLOW);
            r_scan_addr  <= '0;
            r_add_idx    <= tkss_pkg::IDX_W'(i_entry);
            r_add_amt    <= i_amount;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_found : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.push |-> r_found)
        else $error("result pushed without a selected entry");

    a_push_untaken : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.push && r_prev_valid) |-> (r_best_idx != r_prev_idx))
        else $error("entry selected twice in one query");

    a_rank_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tkss_pkg::ST_SCAN || r_state == tkss_pkg::ST_EMIT) |-> (r_rank < r_k))
        else $error("rank ran past the requested count");

    a_last_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.push && o_out.res.last) |=> (r_state == tkss_pkg::ST_IDLE))
        else $error("query did not end after its last result");

    a_cmp_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> (r_cmp_idx <= last_idx))
        else $error("scan read beyond the active entries");
`endif

endmodule

FILE: hdl/tkss_out.sv
// ----------------------------------------------------------------------------
// Top-k score selector output stage
// Result register that holds one beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module tkss_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tkss_pkg::t_out_req               i_req,
    output logic                             o_free,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tkss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);

    logic              r_valid;
    tkss_pkg::t_result r_res;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_req.push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_req.push) begin
            r_res <= i_req.res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = tkss_pkg::OUT_DATA_W'({r_res.rank, r_res.score, r_res.entry_index});
    assign m_axis_tlast  = r_res.last;

endmodule

FILE: hdl/top_k_score_selector.sv
// ----------------------------------------------------------------------------
// Top-k score selector
// Score table with clear, saturating add and best-first top-k queries.
// ----------------------------------------------------------------------------
// A clear is done on acceptance; an add reads the score, then writes the
// saturated sum back. A query over n active entries that returns k results
// makes, for every result, one full pass over the n active entries through
// the single read port of the score RAM, then hands the result to the
// output register, waiting while downstream stalls. Results come best
// first, ties toward the lower index, the final one with tlast.
module top_k_score_selector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] entry, [29:6] amount, [36:30] count_wanted
    input  logic [tkss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  logic [tkss_pkg::ACTION_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] entry_index, [36:6] score, [42:37] rank
    output logic [tkss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tkss_pkg::APB_AW-1:0]      paddr,
    input  logic [tkss_pkg::APB_DW-1:0]      pwdata,
    output logic [tkss_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    logic [tkss_pkg::CNT_W-1:0] active;
    logic                       out_free;
    tkss_pkg::t_out_req         out_req;

    tkss_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_active (active)
    );

    tkss_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_action   (tkss_pkg::t_action'(s_axis_tuser)),
        .i_entry    (s_axis_tdata[5:0]),
        .i_amount   (s_axis_tdata[29:6]),
        .i_want     (s_axis_tdata[36:30]),
        .i_active   (active),
        .i_out_free (out_free),
        .o_out      (out_req)
    );

    tkss_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (out_req),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
